### design/gpr_pkg.sv
// Shared constants, types and state codes of the pyramid reduce block.
package gpr_pkg;

  localparam int unsigned GPR_MAX_WIDTH  = 1024;
  localparam int unsigned GPR_MAX_HEIGHT = 1024;
  localparam int unsigned GPR_PIXEL_BITS = 16;

  localparam int unsigned STORE_ROWS = 5;
  localparam int unsigned REG_DIM_W  = 11;
  localparam int unsigned TAP_W      = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned COORD_W    = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_CENTER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_NEAR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_FAR      = 3'd4;

  localparam logic [REG_DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [REG_DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd1024;
  localparam logic [TAP_W-1:0]     RST_TAP_CENTER   = 16'd26214;
  localparam logic [TAP_W-1:0]     RST_TAP_NEAR     = 16'd16384;
  localparam logic [TAP_W-1:0]     RST_TAP_FAR      = 16'd3277;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_LAUNCH,
    ST_DIV
  } gpr_state_e;

  // Side information carried along the divider chain with each result
  typedef struct packed {
    logic               vld;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
    logic               zero;
  } gpr_tag_t;

endpackage

### design/gaussian_pyramid_reduce_5x5_core.sv
// Top level of the 5x5 Gaussian pyramid reduce block.
//
// Source pixels enter on the input channel (in_valid_i, in_stall_o,
// pixel_value_i) in raster order; reduced pixels leave on the output channel
// (out_valid_o, out_stall_i, out_value_o, out_col_o, out_row_o, run_last_o),
// run_last_o marking the final result caused by one source item.
// A source item that completes no window is stored without stalling the input.
// One that completes windows yields 1, 2 or 4 results, each worked by window
// reads through the single read port of the five-row store, a multiply and
// accumulate drain, a launch step and the divider chain. About one in four
// source items causes results. in_stall_o is high while results are worked.
// A finished result waits in the output register while the next window is
// read; the divider launches only once that register is empty, so a stalled
// receiver holds the block back without losing anything.
// Reset restores the register defaults and starts a new frame; the row store
// is not cleared. Writing image_width or image_height restarts the frame.
module gaussian_pyramid_reduce_5x5_core import gpr_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = GPR_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = GPR_MAX_HEIGHT,
  parameter int unsigned PIXEL_BITS = GPR_PIXEL_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [15:0]           pixel_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OUT_W-1:0]      out_value_o,
  output logic [COORD_W-1:0]    out_col_o,
  output logic [COORD_W-1:0]    out_row_o,
  output logic                  run_last_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned KW    = (CW > RW) ? CW : RW;
  localparam int unsigned LW    = KW + 1;
  localparam int unsigned GW    = (LW > REG_DIM_W) ? LW : REG_DIM_W;
  localparam int unsigned SW    = KW + 3;
  localparam int unsigned DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned WT_W  = 2 * TAP_W;
  localparam int unsigned PR_W  = PIXEL_BITS + WT_W;
  localparam int unsigned DEN_W = WT_W + 5;
  localparam int unsigned NUM_W = PR_W + 5;

  // Configuration registers
  logic [REG_DIM_W-1:0] width_q, height_q;
  logic [TAP_W-1:0]     tapc_q, tapn_q, tapf_q;

  // Frame position
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [2:0]    slot_q;

  // Item and window sequencing
  gpr_state_e    state_q, state_d;
  logic [KW-1:0] tx0_q, tx1_q, ty0_q, ty1_q;
  logic [1:0]    nx_q, ny_q;
  logic          i_q, j_q;
  logic [RW-1:0] rcur_q;
  logic [2:0]    rslot_q;
  logic [2:0]    dx_q, dy_q;
  logic          drn_q;

  // Multiply and accumulate pipeline
  logic              a_use_q, a_rd_q;
  logic [WT_W-1:0]   a_wt_q;
  logic              b_use_q;
  logic [WT_W-1:0]   b_wt_q;
  logic [PR_W-1:0]   prod_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;

  // Output register
  logic               out_valid_q;
  logic [OUT_W-1:0]   out_value_q;
  logic [COORD_W-1:0] out_col_q, out_row_q;
  logic               out_last_q;

  // Controller outputs
  logic scan_en, launch, res_done, more;

  logic [LW-1:0] w_eff, h_eff;
  logic          in_acc;

  function automatic logic [LW-1:0] clamp_dim(input logic [REG_DIM_W-1:0] v,
                                              input logic [GW-1:0] maxv);
    logic [GW-1:0] g;
    g = GW'(v);
    if (g == '0) begin
      g = GW'(1);
    end else if (g > maxv) begin
      g = maxv;
    end
    return LW'(g);
  endfunction

  // Reduced positions along one axis completed by source position pos
  function automatic logic [2*KW+1:0] trig(input logic [KW-1:0] pos,
                                           input logic [LW-1:0] len);
    logic [KW+1:0] half, first, k, t, lm1, p;
    logic [1:0]    n;
    logic [KW-1:0] k0, k1;
    p     = (KW+2)'(pos);
    half  = ((KW+2)'(len) + (KW+2)'(1)) >> 1;
    lm1   = (KW+2)'(len) - (KW+2)'(1);
    first = (p >= (KW+2)'(2)) ? ((p - (KW+2)'(1)) >> 1) : '0;
    n     = 2'd0;
    k0    = '0;
    k1    = '0;
    for (int m = 0; m < 3; m++) begin
      k = first + (KW+2)'(m);
      t = (k << 1) + (KW+2)'(2);
      if (t > lm1) begin
        t = lm1;
      end
      if (k < half && t == p && n < 2'd2) begin
        if (n == 2'd0) begin
          k0 = KW'(k);
        end else begin
          k1 = KW'(k);
        end
        n = n + 2'd1;
      end
    end
    return {n, k1, k0};
  endfunction

  function automatic logic [TAP_W-1:0] tap_sel(input logic [2:0] d,
                                              input logic [TAP_W-1:0] c,
                                              input logic [TAP_W-1:0] nr,
                                              input logic [TAP_W-1:0] fr);
    logic [TAP_W-1:0] v;
    unique case (d)
      3'd2:       v = c;
      3'd1, 3'd3: v = nr;
      default:    v = fr;
    endcase
    return v;
  endfunction

  assign w_eff  = clamp_dim(width_q, GW'(MAX_WIDTH));
  assign h_eff  = clamp_dim(height_q, GW'(MAX_HEIGHT));
  assign in_acc = in_valid_i && (state_q == ST_IDLE);

  // Triggers of the incoming item
  logic [2*KW+1:0] trig_x, trig_y;
  assign trig_x = trig(KW'(col_q), w_eff);
  assign trig_y = trig(KW'(row_q), h_eff);

  logic [LW-1:0] col_nxt, row_nxt;
  assign col_nxt = LW'(col_q) + LW'(1);
  assign row_nxt = LW'(row_q) + LW'(1);

  // Configuration and frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      tapc_q   <= RST_TAP_CENTER;
      tapn_q   <= RST_TAP_NEAR;
      tapf_q   <= RST_TAP_FAR;
      col_q    <= '0;
      row_q    <= '0;
      slot_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH: begin
          width_q <= cfg_data_i[REG_DIM_W-1:0];
          col_q   <= '0;
          row_q   <= '0;
          slot_q  <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_q <= cfg_data_i[REG_DIM_W-1:0];
          col_q    <= '0;
          row_q    <= '0;
          slot_q   <= '0;
        end
        REG_TAP_CENTER: tapc_q <= cfg_data_i[TAP_W-1:0];
        REG_TAP_NEAR:   tapn_q <= cfg_data_i[TAP_W-1:0];
        REG_TAP_FAR:    tapf_q <= cfg_data_i[TAP_W-1:0];
        default: ;
      endcase
    end else if (in_acc) begin
      if (col_nxt >= w_eff) begin
        col_q <= '0;
        if (row_nxt >= h_eff) begin
          row_q  <= '0;
          slot_q <= '0;
        end else begin
          row_q  <= RW'(row_nxt);
          slot_q <= (slot_q == 3'(STORE_ROWS - 1)) ? 3'd0 : slot_q + 3'd1;
        end
      end else begin
        col_q <= CW'(col_nxt);
      end
    end
  end

  // Window neighbour for the current scan step
  logic signed [SW-1:0] cx, cy, rx, ry, rdiff;
  logic                 nb_valid;
  logic [2:0]           diff, nslot;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WT_W-1:0]      wt_d;
  logic [TAP_W-1:0]     tapx, tapy;

  always_comb begin
    cx    = SW'({(i_q ? tx1_q : tx0_q), 1'b0});
    cy    = SW'({(j_q ? ty1_q : ty0_q), 1'b0});
    rx    = cx + SW'(dx_q) - SW'(2);
    ry    = cy + SW'(dy_q) - SW'(2);
    nb_valid = (rx >= 0) && (rx < SW'(w_eff)) && (ry >= 0) && (ry < SW'(h_eff));
    rdiff = SW'(rcur_q) - ry;
    diff  = rdiff[2:0];
    nslot = (rslot_q >= diff) ? rslot_q - diff : rslot_q + 3'(STORE_ROWS) - diff;
    rd_addr = AW'(nslot) * AW'(MAX_WIDTH) + AW'(rx[KW-1:0]);
    wr_addr = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(col_q);
    tapx  = tap_sel(dx_q, tapc_q, tapn_q, tapf_q);
    tapy  = tap_sel(dy_q, tapc_q, tapn_q, tapf_q);
    wt_d  = nb_valid ? tapx * tapy : '0;
  end

  logic [PIXEL_BITS-1:0] rdata;

  gpr_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wr_addr),
    .wdata_i (PIXEL_BITS'(pixel_value_i)),
    .re_i    (scan_en && nb_valid),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // Next state
  logic scan_last;
  assign scan_last = (dx_q == 3'd4) && (dy_q == 3'd4);

  gpr_tag_t         chain_tag [PIXEL_BITS+1];
  logic [NUM_W-1:0] chain_rem [PIXEL_BITS+1];
  logic [DEN_W-1:0] chain_den [PIXEL_BITS+1];
  logic [PIXEL_BITS-1:0] chain_quo [PIXEL_BITS+1];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && trig_x[2*KW+1:2*KW] != 2'd0 && trig_y[2*KW+1:2*KW] != 2'd0) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN:   if (scan_last) state_d = ST_DRAIN;
      ST_DRAIN:  if (drn_q) state_d = ST_LAUNCH;
      ST_LAUNCH: if (!out_valid_q) state_d = ST_DIV;
      ST_DIV: begin
        if (chain_tag[PIXEL_BITS].vld) begin
          state_d = more ? ST_SCAN : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    scan_en  = (state_q == ST_SCAN);
    launch   = (state_q == ST_LAUNCH) && !out_valid_q;
    res_done = (state_q == ST_DIV) && chain_tag[PIXEL_BITS].vld;
    more     = !(((2'(i_q) + 2'd1) >= nx_q) && ((2'(j_q) + 2'd1) >= ny_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= 1'b0;
      j_q     <= 1'b0;
      dx_q    <= '0;
      dy_q    <= '0;
      drn_q   <= 1'b0;
      a_use_q <= 1'b0;
      b_use_q <= 1'b0;
    end else begin
      state_q <= state_d;
      a_use_q <= scan_en;
      b_use_q <= a_use_q;
      if (in_acc) begin
        i_q  <= 1'b0;
        j_q  <= 1'b0;
        dx_q <= '0;
        dy_q <= '0;
      end else if (scan_en) begin
        if (dx_q == 3'd4) begin
          dx_q <= '0;
          dy_q <= (dy_q == 3'd4) ? 3'd0 : dy_q + 3'd1;
        end else begin
          dx_q <= dx_q + 3'd1;
        end
      end else if (res_done && more) begin
        // Advance to the next window of the same item, column first
        if ((2'(i_q) + 2'd1) < nx_q) begin
          i_q <= 1'b1;
        end else begin
          i_q <= 1'b0;
          j_q <= 1'b1;
        end
      end
      drn_q <= (state_q == ST_DRAIN) ? !drn_q : 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tx0_q   <= trig_x[KW-1:0];
      tx1_q   <= trig_x[2*KW-1:KW];
      nx_q    <= trig_x[2*KW+1:2*KW];
      ty0_q   <= trig_y[KW-1:0];
      ty1_q   <= trig_y[2*KW-1:KW];
      ny_q    <= trig_y[2*KW+1:2*KW];
      rcur_q  <= row_q;
      rslot_q <= slot_q;
    end
    a_wt_q <= wt_d;
    a_rd_q <= scan_en && nb_valid;
    b_wt_q <= a_wt_q;
    prod_q <= a_rd_q ? PR_W'(a_wt_q * rdata) : '0;
    if (in_acc || (res_done && more)) begin
      num_q <= '0;
      den_q <= '0;
    end else if (b_use_q) begin
      num_q <= num_q + NUM_W'(prod_q);
      den_q <= den_q + DEN_W'(b_wt_q);
    end
  end

  // Divider chain, most significant quotient bit first
  always_comb begin
    chain_tag[0].vld  = launch;
    chain_tag[0].col  = COORD_W'(i_q ? tx1_q : tx0_q);
    chain_tag[0].row  = COORD_W'(j_q ? ty1_q : ty0_q);
    chain_tag[0].last = !more;
    chain_tag[0].zero = (den_q == '0);
    chain_rem[0]      = num_q;
    chain_den[0]      = den_q;
    chain_quo[0]      = '0;
  end

  for (genvar g = 0; g < PIXEL_BITS; g++) begin : g_div
    gpr_div_cell #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .Q_W   (PIXEL_BITS),
      .SHIFT (PIXEL_BITS - 1 - g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tag_i  (chain_tag[g]),
      .rem_i  (chain_rem[g]),
      .den_i  (chain_den[g]),
      .quo_i  (chain_quo[g]),
      .tag_o  (chain_tag[g+1]),
      .rem_o  (chain_rem[g+1]),
      .den_o  (chain_den[g+1]),
      .quo_o  (chain_quo[g+1])
    );
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_done) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_done) begin
      out_value_q <= chain_tag[PIXEL_BITS].zero ? '0 : OUT_W'(chain_quo[PIXEL_BITS]);
      out_col_q   <= chain_tag[PIXEL_BITS].col;
      out_row_q   <= chain_tag[PIXEL_BITS].row;
      out_last_q  <= chain_tag[PIXEL_BITS].last;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign run_last_o  = out_last_q;

endmodule

### design/gpr_ram.sv
// Generic simple dual-port RAM with registered read data.
module gpr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 5120
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/gpr_div_cell.sv
// One restoring-division cell: settles one quotient bit and passes the remainder on.
module gpr_div_cell import gpr_pkg::*; #(
  parameter int unsigned NUM_W = 53,
  parameter int unsigned DEN_W = 37,
  parameter int unsigned Q_W   = 16,
  parameter int unsigned SHIFT = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gpr_tag_t         tag_i,
  input  logic [NUM_W-1:0] rem_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [Q_W-1:0]   quo_i,
  output gpr_tag_t         tag_o,
  output logic [NUM_W-1:0] rem_o,
  output logic [DEN_W-1:0] den_o,
  output logic [Q_W-1:0]   quo_o
);

  logic [NUM_W-1:0]   sh;
  logic               ge;
  logic [NUM_W-1:0]   rem_d;
  logic [Q_W-1:0]     quo_d;
  logic               vld_q;
  logic [COORD_W-1:0] col_q;
  logic [COORD_W-1:0] row_q;
  logic               last_q;
  logic               zero_q;
  logic [NUM_W-1:0]   rem_q;
  logic [DEN_W-1:0]   den_q;
  logic [Q_W-1:0]     quo_q;

  always_comb begin
    sh    = NUM_W'(den_i) << SHIFT;
    ge    = rem_i >= sh;
    rem_d = ge ? rem_i - sh : rem_i;
    quo_d = quo_i;
    quo_d[SHIFT] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tag_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q  <= tag_i.col;
    row_q  <= tag_i.row;
    last_q <= tag_i.last;
    zero_q <= tag_i.zero;
    rem_q  <= rem_d;
    den_q  <= den_i;
    quo_q  <= quo_d;
  end

  assign tag_o.vld  = vld_q;
  assign tag_o.col  = col_q;
  assign tag_o.row  = row_q;
  assign tag_o.last = last_q;
  assign tag_o.zero = zero_q;
  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;

endmodule
